FILE: design/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// types and codes shared by the sorted record table
// ----------------------------------------------------------------------------
package srt_pkg;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT_AT  = 3'd1,
    OP_DELETE_AT  = 3'd2,
    OP_DELETE_KEY = 3'd3,
    OP_SORT_KEY   = 3'd4,
    OP_SORT_DATE  = 3'd5,
    OP_SEARCH     = 3'd6,
    OP_READ_AT    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADDOSE  = 3'd4
  } status_e;

  localparam logic [1:0] DoseLimit = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [1:0]  doses;
    logic [11:0] fy;
    logic [3:0]  fm;
    logic [4:0]  fd;
    logic [11:0] sy;
    logic [3:0]  sm;
    logic [4:0]  sd;
  } rec_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  position;
    logic [63:0] search_key;
    logic [1:0]  dose_count;
    logic [11:0] first_year;
    logic [3:0]  first_month;
    logic [4:0]  first_day;
    logic [11:0] second_year;
    logic [3:0]  second_month;
    logic [4:0]  second_day;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  found_position;
    logic [63:0] rec_key;
    logic [1:0]  rec_doses;
    logic [11:0] rec_first_year;
    logic [3:0]  rec_first_month;
    logic [4:0]  rec_first_day;
    logic [11:0] rec_second_year;
    logic [3:0]  rec_second_month;
    logic [4:0]  rec_second_day;
    logic [7:0]  entry_count;
  } rsp_t;

  function automatic logic [20:0] date_code(rec_t r);
    return {r.fy, r.fm, r.fd};
  endfunction

endpackage

FILE: design/sorted_record_table_core.sv
// ----------------------------------------------------------------------------
// sorted_record_table_core
// record table in one synchronous ram, edited by a read-modify-write sequencer
// ----------------------------------------------------------------------------
// sequencing: insert and delete move each shifted entry in turn, delete by key
//   first scans the entries, sorts run outer steps with moves, search runs a
//   key sort and then binary search probes
// throughput: one request at a time, the next is taken from the cycle after
//   the response is accepted; one ram read and one ram write per cycle
// reset: fill count clears, ram contents stay undefined and are never read
module sorted_record_table_core #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_ready,
  input  srt_pkg::req_t   in_data_i,
  output logic            out_valid,
  input  logic            out_ready,
  output srt_pkg::rsp_t   out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,  // issue read
    S_RW    = 11'b00000000100,  // data back
    S_SORTI = 11'b00000001000,  // sort outer: read element i
    S_SORTT = 11'b00000010000,  // latch t, read j-1
    S_SORTC = 11'b00000100000,  // compare j-1 with t
    S_SRCH  = 11'b00001000000,  // search probe read
    S_SRCW  = 11'b00010000000,  // search compare, or place t at entry 0 for a sort
    S_SCAN  = 11'b00100000000,  // delete key scan compare
    S_SHIFT = 11'b01000000000,  // shift data back
    S_RESP  = 11'b10000000000
  } state_e;

  state_e          state_q, state_d;
  srt_pkg::req_t   req_q;
  srt_pkg::rec_t   nr;
  logic [CW-1:0]   fill_q, fill_d;
  logic [CW:0]     i_q, i_d, j_q, j_d;
  logic [CW:0]     lo_q, lo_d, hi_q, hi_d;
  srt_pkg::rec_t   t_q, t_d, hold_q, hold_d;
  logic            by_date_q, by_date_d;
  logic            up_q, up_d;        // shift direction: up for insert, down for delete
  logic [CW-1:0]   pos_q, pos_d;
  srt_pkg::rsp_t   rsp_q, rsp_d;
  logic            ov_q, ov_d;

  // ram
  srt_pkg::rec_t   mem [CAPACITY];
  srt_pkg::rec_t   rdata_q;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  srt_pkg::rec_t   wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  assign in_ready   = (state_q == S_IDLE) && !ov_q;
  assign out_valid  = ov_q;
  assign out_data_o = rsp_q;

  always_comb begin
    nr = '{key: req_q.search_key, doses: req_q.dose_count,
           fy: req_q.first_year, fm: req_q.first_month, fd: req_q.first_day,
           sy: req_q.second_year, sm: req_q.second_month, sd: req_q.second_day};
    if (req_q.dose_count < 2'd1) begin
      nr.fy = '0; nr.fm = '0; nr.fd = '0;
    end
    if (req_q.dose_count < 2'd2) begin
      nr.sy = '0; nr.sm = '0; nr.sd = '0;
    end
  end

  function automatic srt_pkg::rsp_t mk(logic [2:0] st, logic [CW-1:0] p,
                                       srt_pkg::rec_t r, logic [CW-1:0] f);
    srt_pkg::rsp_t o;
    o.status = st;
    o.found_position = 7'(p);
    o.rec_key = r.key; o.rec_doses = r.doses;
    o.rec_first_year = r.fy; o.rec_first_month = r.fm; o.rec_first_day = r.fd;
    o.rec_second_year = r.sy; o.rec_second_month = r.sm;
    o.rec_second_day = r.sd;
    o.entry_count = 8'(f);
    return o;
  endfunction

  logic greater;
  logic [CW:0] mid;
  always_comb begin
    greater = by_date_q ? (srt_pkg::date_code(rdata_q) > srt_pkg::date_code(t_q))
                        : (rdata_q.key > t_q.key);
    mid = (lo_q + hi_q) >> 1;
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; i_d = i_q; j_d = j_q; lo_d = lo_q;
    hi_d = hi_q; t_d = t_q; hold_d = hold_q; by_date_d = by_date_q;
    up_d = up_q; pos_d = pos_q; rsp_d = rsp_q; ov_d = ov_q;
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = rdata_q;
    if (ov_q && out_ready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid && in_ready) state_d = S_RD;
      end
      S_RD: begin
        // dispatch
        case (req_q.op)
          srt_pkg::OP_APPEND, srt_pkg::OP_INSERT_AT: begin
            logic [CW-1:0] p;
            p = (req_q.op == srt_pkg::OP_APPEND) ? fill_q : CW'(req_q.position);
            if ({1'b0, req_q.position} > {1'b0, fill_q} &&
                req_q.op == srt_pkg::OP_INSERT_AT) begin
              rsp_d = mk(srt_pkg::ST_BADPOS, '0, '0, fill_q); state_d = S_RESP;
            end else if (fill_q >= CW'(CAPACITY)) begin
              rsp_d = mk(srt_pkg::ST_FULL, '0, '0, fill_q); state_d = S_RESP;
            end else if (req_q.dose_count > srt_pkg::DoseLimit) begin
              rsp_d = mk(srt_pkg::ST_BADDOSE, '0, '0, fill_q); state_d = S_RESP;
            end else begin
              pos_d = p; up_d = 1'b1; i_d = (CW+1)'(fill_q);
              if (fill_q == p) begin
                we = 1'b1; waddr = AW'(p); wdata = nr;
                fill_d = fill_q + 1'b1;
                rsp_d = mk(srt_pkg::ST_OK, p, nr, fill_q + 1'b1);
                state_d = S_RESP;
              end else begin
                re = 1'b1; raddr = AW'(fill_q - 1'b1); state_d = S_SHIFT;
              end
            end
          end
          srt_pkg::OP_DELETE_AT, srt_pkg::OP_READ_AT: begin
            if ({1'b0, req_q.position} >= {1'b0, fill_q}) begin
              rsp_d = mk(srt_pkg::ST_BADPOS, '0, '0, fill_q); state_d = S_RESP;
            end else begin
              re = 1'b1; raddr = AW'(req_q.position);
              pos_d = CW'(req_q.position); state_d = S_RW;
            end
          end
          srt_pkg::OP_DELETE_KEY: begin
            if (fill_q == '0) begin
              rsp_d = mk(srt_pkg::ST_NOTFOUND, '0, '0, fill_q); state_d = S_RESP;
            end else begin
              re = 1'b1; raddr = '0; i_d = '0; state_d = S_SCAN;
            end
          end
          default: begin
            // sorts and search: i starts at 1
            by_date_d = (req_q.op == srt_pkg::OP_SORT_DATE);
            i_d = (CW+1)'(1); state_d = S_SORTI;
          end
        endcase
      end
      S_RW: begin
        hold_d = rdata_q;
        if (req_q.op == srt_pkg::OP_READ_AT) begin
          rsp_d = mk(srt_pkg::ST_OK, pos_q, rdata_q, fill_q); state_d = S_RESP;
        end else begin
          // remove at pos_q: move i+1 down to i
          up_d = 1'b0; i_d = (CW+1)'(pos_q);
          if ((CW+1)'(pos_q) + 1'b1 >= (CW+1)'(fill_q)) begin
            fill_d = fill_q - 1'b1;
            rsp_d = mk(srt_pkg::ST_OK, pos_q, rdata_q, fill_q - 1'b1);
            state_d = S_RESP;
          end else begin
            re = 1'b1; raddr = AW'(pos_q + 1'b1); state_d = S_SHIFT;
          end
        end
      end
      S_SCAN: begin
        if (rdata_q.key == req_q.search_key) begin
          re = 1'b1; raddr = AW'(i_q); pos_d = CW'(i_q); state_d = S_RW;
        end else if (i_q + 1'b1 >= (CW+1)'(fill_q)) begin
          rsp_d = mk(srt_pkg::ST_NOTFOUND, '0, '0, fill_q); state_d = S_RESP;
        end else begin
          i_d = i_q + 1'b1; re = 1'b1; raddr = AW'(i_q + 1'b1);
        end
      end
      S_SHIFT: begin
        we = 1'b1; wdata = rdata_q;
        if (up_q) begin
          // rdata is entry i-1, goes to i
          waddr = AW'(i_q);
          if (i_q - 1'b1 == (CW+1)'(pos_q)) begin
            // next cycle write new record; done here via second step
            i_d = i_q - 1'b1; state_d = S_RESP;
            rsp_d = mk(srt_pkg::ST_OK, pos_q, nr, fill_q + 1'b1);
            fill_d = fill_q + 1'b1; up_d = 1'b1; hold_d = nr;
            j_d = (CW+1)'(1); // flag: pending write of new record
          end else begin
            i_d = i_q - 1'b1; re = 1'b1; raddr = AW'(i_q - 2'd2);
          end
        end else begin
          // rdata is entry i+1, goes to i
          waddr = AW'(i_q);
          if (i_q + 2'd2 >= (CW+1)'(fill_q)) begin
            fill_d = fill_q - 1'b1;
            rsp_d = mk(srt_pkg::ST_OK, pos_q, hold_q, fill_q - 1'b1);
            state_d = S_RESP;
          end else begin
            i_d = i_q + 1'b1; re = 1'b1; raddr = AW'(i_q + 2'd2);
          end
        end
      end
      S_SORTI: begin
        if (i_q >= (CW+1)'(fill_q)) begin
          if (req_q.op == srt_pkg::OP_SEARCH) begin
            if (fill_q == '0) begin
              rsp_d = mk(srt_pkg::ST_NOTFOUND, '0, '0, fill_q); state_d = S_RESP;
            end else begin
              lo_d = '0; hi_d = (CW+1)'(fill_q) - 1'b1; state_d = S_SRCH;
            end
          end else begin
            rsp_d = mk(srt_pkg::ST_OK, '0, '0, fill_q); state_d = S_RESP;
          end
        end else begin
          re = 1'b1; raddr = AW'(i_q); j_d = i_q; state_d = S_SORTT;
        end
      end
      S_SORTT: begin
        t_d = rdata_q; re = 1'b1; raddr = AW'(j_q - 1'b1); state_d = S_SORTC;
      end
      S_SORTC: begin
        we = 1'b1; waddr = AW'(j_q);
        if (greater) begin
          wdata = rdata_q;
          if (j_q == (CW+1)'(1)) begin
            // entry 0 moves up, t lands in entry 0 on the next cycle
            j_d = '0; state_d = S_SRCW;
          end else begin
            j_d = j_q - 1'b1; re = 1'b1; raddr = AW'(j_q - 2'd2);
          end
        end else begin
          wdata = t_q; i_d = i_q + 1'b1; state_d = S_SORTI;
        end
      end
      S_SRCH: begin
        re = 1'b1; raddr = AW'(mid); state_d = S_SRCW;
      end
      S_SRCW: begin
        if (req_q.op != srt_pkg::OP_SEARCH || i_q < (CW+1)'(fill_q)) begin
          // pending sort step: place t at entry 0
          we = 1'b1; waddr = '0; wdata = t_q;
          i_d = i_q + 1'b1; state_d = S_SORTI;
        end else if (rdata_q.key == req_q.search_key) begin
          rsp_d = mk(srt_pkg::ST_OK, CW'(mid), rdata_q, fill_q); state_d = S_RESP;
        end else if (rdata_q.key > req_q.search_key) begin
          if (mid == lo_q) begin
            rsp_d = mk(srt_pkg::ST_NOTFOUND, '0, '0, fill_q); state_d = S_RESP;
          end else begin
            hi_d = mid - 1'b1; state_d = S_SRCH;
          end
        end else begin
          if (mid + 1'b1 > hi_q) begin
            rsp_d = mk(srt_pkg::ST_NOTFOUND, '0, '0, fill_q); state_d = S_RESP;
          end else begin
            lo_d = mid + 1'b1; state_d = S_SRCH;
          end
        end
      end
      S_RESP: begin
        if (up_q && j_q == (CW+1)'(1) &&
            (req_q.op == srt_pkg::OP_APPEND || req_q.op == srt_pkg::OP_INSERT_AT)) begin
          we = 1'b1; waddr = AW'(pos_q); wdata = nr; j_d = '0;
        end
        ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      ov_q    <= 1'b0;
      up_q    <= 1'b0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ov_q    <= ov_d;
      up_q    <= up_d;
      j_q     <= (state_q == S_IDLE) ? '0 : j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) req_q <= in_data_i;
    i_q <= i_d; lo_q <= lo_d; hi_q <= hi_d; t_q <= t_d; hold_q <= hold_d;
    by_date_q <= by_date_d; pos_q <= pos_d; rsp_q <= rsp_d;
  end

endmodule

FILE: design/srt_checker.sv
// ----------------------------------------------------------------------------
// srt_checker
// port-level checks for the sorted record table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module srt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input srt_pkg::rsp_t out_data_i
);
  `ASSERT_IMPL(a_ready_excl, clk_i, rst_ni, out_valid, !in_ready, "ready while result waits")
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid && in_ready, !in_ready, "request during busy")
  `ASSERT_IMPL(a_status, clk_i, rst_ni, out_valid, out_data_i.status <= srt_pkg::ST_BADDOSE, "bad status")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, $stable(out_data_i), "data moved")
endmodule

bind sorted_record_table_core srt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data_i(out_data_o)
);
